### rtl/trt_pkg.sv
package trt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int CMD_W   = 2;
  localparam int QID_W   = 16;
  localparam int ADDR_W  = 48;
  localparam int TAG_W   = 16;
  localparam int ASG_W   = 5;
  localparam int STAT_W  = 2;
  localparam int TIME_W  = 32;
  localparam int EXP_W   = 16;

  localparam logic [EXP_W-1:0] EXPIRE_RESET = EXP_W'(10);

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADTAG = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } trt_cmd_t;

endpackage

### rtl/trt_ram.sv
module trt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/trt_ctrl.sv
module trt_ctrl
  import trt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output trt_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, accept, load;

  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == S_LOAD) && out_free;
  assign in_stall = !((state_r == S_IDLE) || load);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // overlap the next request with the result handoff
        if (out_free) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.execute = (state_r == S_EXEC);
  assign cmd.load    = load;

endmodule

### rtl/trt_dpath.sv
module trt_dpath
  import trt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  trt_cmd_t           cmd,
  input  logic               cfg_we,
  input  logic [EXP_W-1:0]   cfg_expire_ticks,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [QID_W-1:0]   in_client_query_id,
  input  logic [ADDR_W-1:0]  in_client_address,
  input  logic [TAG_W-1:0]   in_response_tag,
  output logic [ASG_W-1:0]   out_assigned_tag,
  output logic [QID_W-1:0]   out_restored_query_id,
  output logic [ADDR_W-1:0]  out_restored_address,
  output logic [STAT_W-1:0]  out_status
);

  localparam int ENT_W = QID_W + ADDR_W;

  // request registers
  logic [CMD_W-1:0]  cmd_r;
  logic [QID_W-1:0]  qid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TAG_W-1:0]  tag_r;

  // table state
  logic [EXP_W-1:0]  expire_r;
  logic [TIME_W-1:0] time_r;
  logic [TABLE_ENTRIES-1:0] done_r;
  logic [TABLE_ENTRIES-1:0] written_r;
  logic [TIME_W-1:0] expiry_r [TABLE_ENTRIES];

  // per-request results
  logic [ASG_W-1:0] res_tag_r;
  logic             res_full_r;
  logic             res_bad_r;
  logic             res_written_r;

  logic [ASG_W-1:0]  out_tag_r;
  logic [QID_W-1:0]  out_qid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [STAT_W-1:0] out_stat_r;

  logic [TABLE_ENTRIES-1:0] free_vec;
  logic                     found;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W:0]           tag_sum;
  logic [TIME_W:0]          exp_sum;
  logic [TIME_W-1:0]        new_expiry;
  logic                     tag_bad;
  logic [IDX_W-1:0]         rd_idx;
  logic                     do_reg, do_cmp;
  logic [ENT_W-1:0]         ram_rdata;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      free_vec[i] = done_r[i] || ((expiry_r[i] != '0) && (time_r > expiry_r[i]));
    end
  end

  // find first free slot, lowest index wins
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign tag_sum    = {1'b0, free_idx} + (IDX_W + 1)'(1);
  assign exp_sum    = {1'b0, time_r} + (TIME_W + 1)'(expire_r);
  assign new_expiry = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  assign tag_bad = (tag_r == '0) || (tag_r > TAG_W'(TABLE_ENTRIES));
  assign rd_idx  = IDX_W'(tag_r - TAG_W'(1));

  assign do_reg = cmd.execute && (cmd_r == CMD_REGISTER) && found;
  assign do_cmp = cmd.execute && (cmd_r == CMD_COMPLETE) && !tag_bad;

  trt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_reg),
    .waddr (free_idx),
    .wdata ({qid_r, addr_r}),
    .re    (do_cmp),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      qid_r  <= in_client_query_id;
      addr_r <= in_client_address;
      tag_r  <= in_response_tag;
    end
    if (cmd.execute) begin
      res_tag_r     <= ASG_W'(tag_sum);
      res_full_r    <= !found;
      res_bad_r     <= tag_bad;
      res_written_r <= written_r[rd_idx];
    end
    if (do_reg) begin
      expiry_r[free_idx] <= new_expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expire_r  <= EXPIRE_RESET;
      time_r    <= '0;
      done_r    <= '1;
      written_r <= '0;
    end else begin
      if (cfg_we) begin
        expire_r <= cfg_expire_ticks;
      end
      if (cmd.execute && (cmd_r == CMD_TICK) && (time_r != '1)) begin
        time_r <= time_r + TIME_W'(1);
      end
      if (do_reg) begin
        done_r[free_idx]    <= 1'b0;
        written_r[free_idx] <= 1'b1;
      end
      if (do_cmp) begin
        done_r[rd_idx] <= 1'b1;
      end
    end
  end

  // expiry entries not yet written are masked by done_r
  // having been set at reset, so they need no clear
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tag_r  <= '0;
      out_qid_r  <= '0;
      out_addr_r <= '0;
      out_stat_r <= ST_OK;
      case (cmd_r)
        CMD_REGISTER: begin
          if (res_full_r) begin
            out_stat_r <= ST_FULL;
          end else begin
            out_tag_r <= res_tag_r;
          end
        end
        CMD_COMPLETE: begin
          if (res_bad_r) begin
            out_stat_r <= ST_BADTAG;
          end else if (res_written_r) begin
            out_qid_r  <= ram_rdata[ENT_W-1:ADDR_W];
            out_addr_r <= ram_rdata[ADDR_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_assigned_tag      = out_tag_r;
  assign out_restored_query_id = out_qid_r;
  assign out_restored_address  = out_addr_r;
  assign out_status            = out_stat_r;

endmodule

### rtl/transaction_id_remap_table.sv
// From request accept to result valid the block steps through execute, then load.
// A new request is taken in the load step of the last one; the load of one result overlaps the
// capture of the next, the execute cycle holding the free-slot search and table update.
// A stalled result holds the block in its load step until taken.
// Reset (rst_n, synchronous, active low): all slots free, time 0, timeout 10.
module transaction_id_remap_table
  import trt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [QID_W-1:0]   in_client_query_id,
  input  logic [ADDR_W-1:0]  in_client_address,
  input  logic [TAG_W-1:0]   in_response_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ASG_W-1:0]   out_assigned_tag,
  output logic [QID_W-1:0]   out_restored_query_id,
  output logic [ADDR_W-1:0]  out_restored_address,
  output logic [STAT_W-1:0]  out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [EXP_W-1:0]   cfg_expire_ticks
);

  trt_cmd_t cmd;

  assign cfg_ready = 1'b1;

  trt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  trt_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_expire_ticks      (cfg_expire_ticks),
    .in_command            (in_command),
    .in_client_query_id    (in_client_query_id),
    .in_client_address     (in_client_address),
    .in_response_tag       (in_response_tag),
    .out_assigned_tag      (out_assigned_tag),
    .out_restored_query_id (out_restored_query_id),
    .out_restored_address  (out_restored_address),
    .out_status            (out_status)
  );

endmodule

### dv/tb_transaction_id_remap_table.sv
module tb_transaction_id_remap_table;
  import trt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [ASG_W-1:0]  assigned_tag;
    logic [QID_W-1:0]  query_id;
    logic [ADDR_W-1:0] address;
    logic [STAT_W-1:0] status;
  } remap_reply_t;

  class remap_tracker;
    logic [QID_W-1:0]  slot_query_id [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_address [TABLE_ENTRIES];
    bit                slot_done [TABLE_ENTRIES];
    logic [TIME_W-1:0] slot_expiry [TABLE_ENTRIES];
    logic [TIME_W-1:0] now_ticks;
    logic [EXP_W-1:0]  timeout_ticks;
    remap_reply_t      pending_replies[$];
    int                errors;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_query_id[i] = '0;
        slot_address[i] = '0;
        slot_done[i] = 1'b1;
        slot_expiry[i] = '0;
      end
      now_ticks = '0;
      timeout_ticks = EXPIRE_RESET;
      errors = 0;
    endfunction

    function void set_timeout(input logic [EXP_W-1:0] ticks);
      timeout_ticks = ticks;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Predict the reply for one accepted request and advance the table.
    function void note_request(input logic [CMD_W-1:0] cmd, input logic [QID_W-1:0] qid,
                               input logic [ADDR_W-1:0] addr, input logic [TAG_W-1:0] tag);
      remap_reply_t r;
      logic [TIME_W:0] deadline;
      bit found;
      int idx;
      r = '0;
      found = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (now_ticks != {TIME_W{1'b1}}) now_ticks = now_ticks + 1'b1;
        end
        CMD_REGISTER: begin
          deadline = {1'b0, now_ticks} + timeout_ticks;
          for (idx = 0; idx < TABLE_ENTRIES; idx++) begin
            if (!found && (slot_done[idx] ||
                (slot_expiry[idx] != '0 && now_ticks > slot_expiry[idx]))) begin
              slot_query_id[idx] = qid;
              slot_address[idx] = addr;
              slot_done[idx] = 1'b0;
              slot_expiry[idx] = deadline[TIME_W] ? {TIME_W{1'b1}} : deadline[TIME_W-1:0];
              r.assigned_tag = ASG_W'(idx + 1);
              found = 1'b1;
            end
          end
          if (!found) r.status = ST_FULL;
        end
        CMD_COMPLETE: begin
          if (tag == '0 || tag > TABLE_ENTRIES) begin
            r.status = ST_BADTAG;
          end else begin
            idx = int'(tag) - 1;
            r.query_id = slot_query_id[idx];
            r.address = slot_address[idx];
            slot_done[idx] = 1'b1;
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(input logic [ASG_W-1:0] tag, input logic [QID_W-1:0] qid,
                              input logic [ADDR_W-1:0] addr, input logic [STAT_W-1:0] status);
      remap_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none actual tag %0h id %0h addr %0h status %0h",
                 $time, tag, qid, addr, status);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      report_field("assigned_tag", 64'(want.assigned_tag), 64'(tag));
      report_field("restored_query_id", 64'(want.query_id), 64'(qid));
      report_field("restored_address", 64'(want.address), 64'(addr));
      report_field("status", 64'(want.status), 64'(status));
    endfunction

    function void flush_missing();
      while (pending_replies.size() != 0) begin
        $display("%0t: missing reply, expected status %0h actual none", $time,
                 pending_replies[0].status);
        errors++;
        void'(pending_replies.pop_front());
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = CMD_TICK;
  logic [QID_W-1:0]  in_client_query_id = '0;
  logic [ADDR_W-1:0] in_client_address = '0;
  logic [TAG_W-1:0]  in_response_tag = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ASG_W-1:0]  out_assigned_tag;
  logic [QID_W-1:0]  out_restored_query_id;
  logic [ADDR_W-1:0] out_restored_address;
  logic [STAT_W-1:0] out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [EXP_W-1:0]  cfg_expire_ticks = '0;

  remap_tracker tracker = new();
  int idle_pct = 0;
  int stall_pct = 0;

  transaction_id_remap_table dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_client_query_id    (in_client_query_id),
    .in_client_address     (in_client_address),
    .in_response_tag       (in_response_tag),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_assigned_tag      (out_assigned_tag),
    .out_restored_query_id (out_restored_query_id),
    .out_restored_address  (out_restored_address),
    .out_status            (out_status),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_expire_ticks      (cfg_expire_ticks)
  );

  always #5 clk = ~clk;

  // Check with the stall value the block saw at this edge, then pick the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_reply(out_assigned_tag, out_restored_query_id, out_restored_address,
                          out_status);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Leave valid high after acceptance; lower it only for a gap or a drain.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [QID_W-1:0] qid,
                              input logic [ADDR_W-1:0] addr, input logic [TAG_W-1:0] tag);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_client_query_id <= qid;
    in_client_address <= addr;
    in_response_tag <= tag;
    do @(posedge clk); while (in_stall);
    tracker.note_request(cmd, qid, addr, tag);
  endtask

  task automatic send_random_request();
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [TAG_W-1:0] tag;
    pick = $urandom_range(99);
    if (pick < 3) cmd = CMD_UNUSED;
    else if (pick < 33) cmd = CMD_TICK;
    else if (pick < 68) cmd = CMD_REGISTER;
    else cmd = CMD_COMPLETE;
    tag = TAG_W'($urandom_range(1, TABLE_ENTRIES));
    if ($urandom_range(99) < 12)
      tag = $urandom_range(1) ? '0 : TAG_W'($urandom_range(TABLE_ENTRIES + 1, 65535));
    send_request(cmd, QID_W'($urandom), ADDR_W'({$urandom, $urandom}), tag);
  endtask

  // Hold the sender until every reply is back, then let the block settle.
  task automatic drain_replies(input int settle);
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending() != 0) tracker.flush_missing();
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [EXP_W-1:0] ticks);
    cfg_valid <= 1'b1;
    cfg_expire_ticks <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_timeout(ticks);
  endtask

  initial begin
    logic [EXP_W-1:0] timeouts [8];
    timeouts = '{16'd1, 16'hFFFF, 16'd0, 16'd4, EXP_W'($urandom_range(2, 30)), 16'd12,
                 EXP_W'($urandom_range(1, 65535)), 16'd2};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad tags, unused command, extremes, re-complete, then fill to full.
    send_request(CMD_COMPLETE, '0, '0, '0);
    send_request(CMD_COMPLETE, '1, '1, TAG_W'(TABLE_ENTRIES + 1));
    send_request(CMD_COMPLETE, '0, '0, '1);
    send_request(CMD_UNUSED, '1, '1, '1);
    send_request(CMD_REGISTER, '1, '1, '0);
    send_request(CMD_REGISTER, '0, '0, '1);
    send_request(CMD_COMPLETE, '0, '0, TAG_W'(1));
    send_request(CMD_COMPLETE, '0, '0, TAG_W'(1));
    send_request(CMD_COMPLETE, '0, '0, TAG_W'(TABLE_ENTRIES));
    repeat (TABLE_ENTRIES - 1)
      send_request(CMD_REGISTER, QID_W'($urandom), ADDR_W'({$urandom, $urandom}), '0);
    send_request(CMD_REGISTER, '1, '1, '0);
    drain_replies(SETTLE_CYCLES);

    for (int phase = 0; phase < 8; phase++) begin
      write_timeout(timeouts[phase]);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_request();
        if ($urandom_range(63) == 0) drain_replies(1);
      end
      drain_replies(SETTLE_CYCLES);
    end

    stall_pct = 0;
    drain_replies(4 * SETTLE_CYCLES);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
